// ===== rtl/ipmb_receive_frame_queue_macros.svh =====
// ----------------------------------------------------------------------------
// IPMB receive frame queue assertion macros
// Clocked assertions on clk_i, held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef IPMB_RECEIVE_FRAME_QUEUE_MACROS_SVH
`define IPMB_RECEIVE_FRAME_QUEUE_MACROS_SVH
`ifndef SYNTH
// property must hold at every clock edge out of reset
`define RFQ_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rfq assertion failed");
// boolean condition must never be true
`define RFQ_ASSERT_NEVER(label, cond) `RFQ_ASSERT(label, !(cond))
`else
`define RFQ_ASSERT(label, prop)
`define RFQ_ASSERT_NEVER(label, cond)
`endif
`endif

// ===== rtl/ipmb_rfq_pkg.sv =====
// ----------------------------------------------------------------------------
// IPMB receive frame queue package
// Shared widths, codes, defaults and the configuration struct.
// ----------------------------------------------------------------------------
package ipmb_rfq_pkg;

  // default sizing
  localparam int unsigned QueueDepthDefault = 8;
  localparam int unsigned MaxPayloadDefault = 255;
  localparam int unsigned HEADER_BYTES      = 3;

  // field widths
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned QCNT_W   = 4;
  localparam int unsigned ADDR7_W  = 7;

  // APB
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // event codes
  typedef enum logic [FUNC_W-1:0] {
    FN_START = 3'd0,
    FN_BYTE  = 3'd1,
    FN_STOP  = 3'd2,
    FN_READ  = 3'd3,
    FN_DROP  = 3'd4
  } func_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_NACK    = 3'd1,
    ST_FULL    = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_IGNORED = 3'd4
  } status_e;

  // register index (paddr[2])
  typedef enum logic {
    REG_OWN_ADDR     = 1'b0,
    REG_CHECK_HEADER = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [ADDR7_W-1:0] own_address;
    logic               check_header;
  } cfg_t;

endpackage

// ===== rtl/ipmb_rfq_if.sv =====
// ----------------------------------------------------------------------------
// IPMB receive frame queue channels
// Valid/ready interfaces for bus events in and results out.
// ----------------------------------------------------------------------------
interface ipmb_rfq_in_if;
  logic                             valid;
  logic                             ready;
  logic [ipmb_rfq_pkg::FUNC_W-1:0]  func;
  logic [ipmb_rfq_pkg::BYTE_W-1:0]  data;

  modport source (output valid, func, data, input ready);
  modport sink   (input valid, func, data, output ready);
endinterface

interface ipmb_rfq_out_if;
  logic                              valid;
  logic                              ready;
  logic [ipmb_rfq_pkg::STATUS_W-1:0] status;
  logic [ipmb_rfq_pkg::BYTE_W-1:0]   rd_data;
  logic                              rd_last;
  logic [ipmb_rfq_pkg::QCNT_W-1:0]   queue_count;

  modport source (output valid, status, rd_data, rd_last, queue_count, input ready);
  modport sink   (input valid, status, rd_data, rd_last, queue_count, output ready);
endinterface

// ===== rtl/ipmb_rfq_ram.sv =====
// ----------------------------------------------------------------------------
// IPMB receive frame queue RAM
// Simple dual-port synchronous RAM, one write and one registered read.
// ----------------------------------------------------------------------------
module ipmb_rfq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ipmb_rfq_cfg.sv =====
// ----------------------------------------------------------------------------
// IPMB receive frame queue register file
// APB port holding the own address and the header check enable.
// ----------------------------------------------------------------------------
module ipmb_rfq_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ipmb_rfq_pkg::PADDR_W-1:0]  paddr,
  input  logic [ipmb_rfq_pkg::PDATA_W-1:0]  pwdata,
  output logic [ipmb_rfq_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready,
  output ipmb_rfq_pkg::cfg_t                cfg_o
);
  import ipmb_rfq_pkg::*;

  logic [ADDR7_W-1:0] own_q, own_d;
  logic               chk_q, chk_d;
  logic               wr_en;
  reg_idx_e           reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[2]);

  // write decode
  always_comb begin
    own_d = own_q;
    chk_d = chk_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_OWN_ADDR:     own_d = pwdata[ADDR7_W-1:0];
        REG_CHECK_HEADER: chk_d = pwdata[0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q <= '0;
      chk_q <= 1'b0;
    end else begin
      own_q <= own_d;
      chk_q <= chk_d;
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      REG_OWN_ADDR:     prdata = {{(PDATA_W-ADDR7_W){1'b0}}, own_q};
      REG_CHECK_HEADER: prdata = {{(PDATA_W-1){1'b0}}, chk_q};
      default:          prdata = '0;
    endcase
  end

  assign pready             = 1'b1;
  assign cfg_o.own_address  = own_q;
  assign cfg_o.check_header = chk_q;

endmodule

// ===== rtl/ipmb_rfq_ctrl.sv =====
// ----------------------------------------------------------------------------
// IPMB receive frame queue controller
// Frame assembly, queue pointers and readout around the frame and length RAMs.
// ----------------------------------------------------------------------------
`include "ipmb_receive_frame_queue_macros.svh"

module ipmb_rfq_ctrl #(
  parameter int unsigned QueueDepth = ipmb_rfq_pkg::QueueDepthDefault,
  parameter int unsigned MaxPayload = ipmb_rfq_pkg::MaxPayloadDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ipmb_rfq_pkg::cfg_t cfg_i,
  ipmb_rfq_in_if.sink        req_i,
  ipmb_rfq_out_if.source     rsp_o
);
  import ipmb_rfq_pkg::*;

  localparam int unsigned FrameBytes = MaxPayload + HEADER_BYTES;
  localparam int unsigned IdxW       = $clog2(FrameBytes + 1);
  localparam int unsigned SlotW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);
  localparam int unsigned StoreDepth = QueueDepth * FrameBytes;
  localparam int unsigned AddrW      = $clog2(StoreDepth);

  localparam logic [IdxW-1:0]  FB_I      = IdxW'(FrameBytes);
  localparam logic [IdxW-1:0]  HDR_I     = IdxW'(HEADER_BYTES);
  localparam logic [CntW-1:0]  QD_C      = CntW'(QueueDepth);
  localparam logic [SlotW-1:0] LAST_SLOT = SlotW'(QueueDepth - 1);
  localparam logic [AddrW-1:0] FB_A      = AddrW'(FrameBytes);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  function automatic logic [SlotW-1:0] next_slot(input logic [SlotW-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + SlotW'(1);
  endfunction

  state_e              state_q, state_d;
  logic [FUNC_W-1:0]   func_q, func_d;
  logic [BYTE_W-1:0]   data_q, data_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic                spoiled_q, spoiled_d;
  logic                noroom_q, noroom_d;
  logic [BYTE_W-1:0]   sum_q, sum_d;
  logic [SlotW-1:0]    head_q, head_d;
  logic [SlotW-1:0]    tail_q, tail_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [IdxW-1:0]     off_q, off_d;
  logic                out_valid_q, out_valid_d;
  status_e             status_q, status_d;
  logic [BYTE_W-1:0]   rd_data_q, rd_data_d;
  logic                rd_last_q, rd_last_d;
  logic [QCNT_W-1:0]   qcnt_q, qcnt_d;

  logic                exec_go;
  logic                byte_we;
  logic [IdxW-1:0]     byte_widx;
  logic [BYTE_W-1:0]   byte_wdata;
  logic [AddrW-1:0]    byte_waddr;
  logic [AddrW-1:0]    byte_raddr;
  logic [BYTE_W-1:0]   byte_rdata;
  logic                len_we;
  logic [IdxW-1:0]     len_rdata;
  logic [BYTE_W-1:0]   own_byte;
  logic [BYTE_W-1:0]   sum_add;
  logic [IdxW-1:0]     idx_inc;
  logic [IdxW-1:0]     off_inc;

  // frame byte store, slot-major
  assign byte_raddr = AddrW'(head_q) * FB_A + AddrW'(off_q);
  assign byte_waddr = AddrW'(tail_q) * FB_A + AddrW'(byte_widx);

  ipmb_rfq_ram #(
    .Width (BYTE_W),
    .Depth (StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (byte_we),
    .waddr_i (byte_waddr),
    .wdata_i (byte_wdata),
    .raddr_i (byte_raddr),
    .rdata_o (byte_rdata)
  );

  // committed frame lengths, one per slot
  ipmb_rfq_ram #(
    .Width (IdxW),
    .Depth (QueueDepth)
  ) u_len (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (tail_q),
    .wdata_i (idx_q),
    .raddr_i (head_q),
    .rdata_o (len_rdata)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign exec_go     = (state_q == S_EXEC) && (!out_valid_q || rsp_o.ready);
  assign own_byte    = {cfg_i.own_address, 1'b0};
  assign sum_add     = sum_q + data_q;
  assign idx_inc     = idx_q + IdxW'(1);
  assign off_inc     = off_q + IdxW'(1);

  // event decode and state update
  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    data_d      = data_q;
    idx_d       = idx_q;
    spoiled_d   = spoiled_q;
    noroom_d    = noroom_q;
    sum_d       = sum_q;
    head_d      = head_q;
    tail_d      = tail_q;
    cnt_d       = cnt_q;
    off_d       = off_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    rd_data_d   = rd_data_q;
    rd_last_d   = rd_last_q;
    qcnt_d      = qcnt_q;
    byte_we     = 1'b0;
    byte_widx   = idx_q;
    byte_wdata  = data_q;
    len_we      = 1'b0;

    // result taken downstream
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          func_d  = req_i.func;
          data_d  = req_i.data;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          status_d  = ST_OK;
          rd_data_d = '0;
          rd_last_d = 1'b0;
          case (func_e'(func_q))
            FN_START: begin
              spoiled_d  = 1'b0;
              sum_d      = own_byte;
              noroom_d   = (cnt_q >= QD_C);
              byte_widx  = '0;
              byte_wdata = own_byte;
              byte_we    = (cnt_q < QD_C);
              idx_d      = IdxW'(1);
            end
            FN_BYTE: begin
              if (idx_q == '0) begin
                status_d = ST_IGNORED;
              end else if (!spoiled_q && idx_q < FB_I) begin
                if (idx_q < HDR_I) begin
                  sum_d = sum_add;
                end
                byte_we = !noroom_q;
                idx_d   = idx_inc;
                // header checksum verdict on the third byte
                if (idx_inc == HDR_I && cfg_i.check_header && sum_add != '0) begin
                  spoiled_d = 1'b1;
                  status_d  = ST_NACK;
                end
              end
            end
            FN_STOP: begin
              if (idx_q == '0) begin
                status_d = ST_IGNORED;
              end else if (spoiled_q) begin
                status_d = ST_NACK;
              end else if (idx_q < HDR_I) begin
                status_d = ST_IGNORED;
              end else if (noroom_q || cnt_q >= QD_C) begin
                status_d = ST_FULL;
              end else begin
                len_we = 1'b1;
                tail_d = next_slot(tail_q);
                cnt_d  = cnt_q + CntW'(1);
              end
              idx_d     = '0;
              spoiled_d = 1'b0;
              noroom_d  = 1'b0;
              sum_d     = '0;
            end
            FN_READ: begin
              if (cnt_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                rd_data_d = byte_rdata;
                if (off_inc >= len_rdata || off_inc >= FB_I) begin
                  rd_last_d = 1'b1;
                  head_d    = next_slot(head_q);
                  cnt_d     = cnt_q - CntW'(1);
                  off_d     = '0;
                end else begin
                  off_d = off_inc;
                end
              end
            end
            FN_DROP: begin
              if (cnt_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                head_d = next_slot(head_q);
                cnt_d  = cnt_q - CntW'(1);
                off_d  = '0;
              end
            end
            default: begin
              status_d = ST_IGNORED;
            end
          endcase
          qcnt_d      = QCNT_W'(cnt_d);
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      func_q      <= '0;
      data_q      <= '0;
      idx_q       <= '0;
      spoiled_q   <= 1'b0;
      noroom_q    <= 1'b0;
      sum_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      off_q       <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
      rd_data_q   <= '0;
      rd_last_q   <= 1'b0;
      qcnt_q      <= '0;
    end else begin
      state_q     <= state_d;
      func_q      <= func_d;
      data_q      <= data_d;
      idx_q       <= idx_d;
      spoiled_q   <= spoiled_d;
      noroom_q    <= noroom_d;
      sum_q       <= sum_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      cnt_q       <= cnt_d;
      off_q       <= off_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      rd_data_q   <= rd_data_d;
      rd_last_q   <= rd_last_d;
      qcnt_q      <= qcnt_d;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.rd_data     = rd_data_q;
  assign rsp_o.rd_last     = rd_last_q;
  assign rsp_o.queue_count = qcnt_q;

  // queue occupancy never exceeds the slot count
  `RFQ_ASSERT(a_cnt_max, cnt_q <= QD_C)
  // empty or full queue has its pointers aligned
  `RFQ_ASSERT(a_ptr_align, (cnt_q == '0 || cnt_q == QD_C) |-> (head_q == tail_q))
  // read position stays inside a frame slot
  `RFQ_ASSERT(a_off_range, off_q < FB_I)
  // open frame never grows past a slot
  `RFQ_ASSERT(a_idx_range, idx_q <= FB_I)
  // a new result only appears out of the execute step
  `RFQ_ASSERT(a_rsp_src, $rose(out_valid_q) |-> $past(state_q == S_EXEC))
  // no frame byte is written while waiting on the bus side
  `RFQ_ASSERT_NEVER(a_we_idle, (byte_we || len_we) && state_q == S_IDLE)

endmodule

// ===== rtl/ipmb_receive_frame_queue.sv =====
// ----------------------------------------------------------------------------
// IPMB receive frame queue
// Top level: APB register file plus frame assembly and queue controller.
// ----------------------------------------------------------------------------
// Each bus event item passes through S_IDLE and S_EXEC: in S_IDLE the item
// is taken while the frame byte and length memories are read at the head of
// the queue, and in S_EXEC the result is registered and the memories and
// pointers are updated; S_EXEC follows the synchronous frame memory read.
// A new item is taken while a result still waits on the output; that result
// must be taken before the next one can be registered.
// Frame memory holds QueueDepth slots of MaxPayload + 3 bytes; its contents
// are undefined until written and need no clearing pass after reset.
module ipmb_receive_frame_queue #(
  parameter int unsigned QueueDepth = ipmb_rfq_pkg::QueueDepthDefault,
  parameter int unsigned MaxPayload = ipmb_rfq_pkg::MaxPayloadDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ipmb_rfq_pkg::PADDR_W-1:0]  paddr,
  input  logic [ipmb_rfq_pkg::PDATA_W-1:0]  pwdata,
  output logic [ipmb_rfq_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready,
  ipmb_rfq_in_if.sink                       req_i,
  ipmb_rfq_out_if.source                    rsp_o
);
  import ipmb_rfq_pkg::*;

  cfg_t cfg;

  // configuration registers
  ipmb_rfq_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // frame assembly and queue
  ipmb_rfq_ctrl #(
    .QueueDepth (QueueDepth),
    .MaxPayload (MaxPayload)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .req_i  (req_i),
    .rsp_o  (rsp_o)
  );

endmodule
